### hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ACVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property checked in the cycle after a condition
`define ACVF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) \
    else $error(msg);

`endif

### hdl/acvf_pkg.sv
package acvf_pkg;

  localparam int LANES    = 4;
  localparam int NSTG     = 29;
  localparam int LANE_STG = NSTG - 1;
  localparam int MANT_W   = 51;
  localparam int EXP_W    = 12;
  localparam int SQ_STG   = 5;
  localparam int SQ_ITER  = 5;

  localparam logic [31:0] K_C1      = 32'h3E2AAAFE;
  localparam logic [31:0] K_C2      = 32'h3D997C6C;
  localparam logic [31:0] K_C3      = 32'h3D3A92D5;
  localparam logic [31:0] K_C4      = 32'h3CC37235;
  localparam logic [31:0] K_C5      = 32'h3D2EA2B6;
  localparam logic [31:0] K_PIBY2   = 32'h3FC90FDB;
  localparam logic [31:0] K_PIBY4   = 32'h3F490FDB;
  localparam logic [31:0] K_ABSMASK = 32'h7FFFFFFF;
  localparam logic [31:0] K_HALF    = 32'h3F000000;
  localparam logic [31:0] K_ONE     = 32'h3F800000;
  localparam logic [31:0] K_INF     = 32'h7F800000;
  localparam logic [31:0] K_QNAN    = 32'h7FC00000;
  localparam logic [31:0] K_QBIT    = 32'h00400000;

  // count of beats held in the pipeline
  typedef logic [$clog2(NSTG + 1)-1:0] cnt_t;

  // unrounded value: mant * 2^exp
  typedef struct packed {
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [MANT_W-1:0]       mant;
  } ufp_t;

  // normalize and round to nearest even, with subnormal results
  function automatic logic [31:0] fp_pack(ufp_t u);
    logic [5:0]         lead;
    logic               found;
    logic signed [13:0] e_unb;
    logic signed [13:0] f;
    logic signed [13:0] sh;
    logic signed [13:0] nsh;
    logic [63:0]        mw;
    logic [63:0]        kept;
    logic [63:0]        low_mask;
    logic               g;
    logic               st;
    logic               up;
    logic [24:0]        m25;
    logic [7:0]         field;
    logic [31:0]        res;
    found = 1'b0;
    lead  = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (u.mant[i]) begin
        lead  = 6'(i);
        found = 1'b1;
      end
    end
    mw    = {{(64 - MANT_W){1'b0}}, u.mant};
    e_unb = $signed({8'b0, lead}) + 14'(u.exp) + 14'sd127;
    f     = (e_unb < 14'sd1) ? 14'sd1 : e_unb;
    sh    = f - 14'sd150 - 14'(u.exp);
    nsh   = -sh;
    low_mask = '0;
    if (sh <= 14'sd0) begin
      kept = mw << nsh[5:0];
      g    = 1'b0;
      st   = 1'b0;
    end else if (sh > 14'sd60) begin
      kept = '0;
      g    = 1'b0;
      st   = 1'b1;
    end else begin
      kept     = mw >> sh[5:0];
      g        = mw[sh[5:0] - 6'd1];
      low_mask = (64'd1 << (sh[5:0] - 6'd1)) - 64'd1;
      st       = |(mw & low_mask);
    end
    up  = g & (st | kept[0]);
    m25 = kept[24:0] + {24'b0, up};
    if (m25[24]) begin
      f   = f + 14'sd1;
      m25 = m25 >> 1;
    end
    if (f >= 14'sd255) begin
      res = {u.sign, K_INF[30:0]};
    end else begin
      field = (f == 14'sd1 && !m25[23]) ? 8'd0 : f[7:0];
      res   = {u.sign, field, m25[22:0]};
    end
    if (!found) begin
      res = {u.sign, 31'b0};
    end
    return res;
  endfunction

endpackage

### hdl/acvf_fmul.sv
module acvf_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  acvf_pkg::ufp_t raw_d, raw_q;

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic [47:0] prod;

  always_comb begin
    ea   = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb   = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma   = {|a_i[30:23], a_i[22:0]};
    mb   = {|b_i[30:23], b_i[22:0]};
    prod = ma * mb;
    raw_d.sign = a_i[31] ^ b_i[31];
    raw_d.exp  = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300;
    raw_d.mant = {3'b0, prod};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q <= raw_d;
    end
  end

  assign y_o = acvf_pkg::fp_pack(raw_q);

endmodule

### hdl/acvf_fadd.sv
module acvf_fadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  acvf_pkg::ufp_t raw_d, raw_q;

  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, diff;
  logic [23:0] mb, ms;
  logic [50:0] bigm, smf, sm;
  logic        lost;
  logic        sub;
  logic [50:0] sum;

  always_comb begin
    swap = b_i[30:0] > a_i[30:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb   = {|big[30:23], big[22:0]};
    ms   = {|sml[30:23], sml[22:0]};
    diff = eb - es;
    bigm = {1'b0, mb, 26'b0};
    smf  = {1'b0, ms, 26'b0};
    if (diff >= 8'd51) begin
      sm   = '0;
      lost = |ms;
    end else begin
      sm   = smf >> diff;
      lost = |(smf & ((51'd1 << diff) - 51'd1));
    end
    // sticky jam keeps rounding exact after subtraction
    sm[0] = sm[0] | lost;
    sub   = a_i[31] ^ b_i[31];
    sum   = sub ? (bigm - sm) : (bigm + sm);
    raw_d.sign = (sub && sum == '0) ? 1'b0 : big[31];
    raw_d.exp  = $signed({4'b0, eb}) - 12'sd176;
    raw_d.mant = sum;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q <= raw_d;
    end
  end

  assign y_o = acvf_pkg::fp_pack(raw_q);

endmodule

### hdl/acvf_sqrt.sv
module acvf_sqrt (
  input  logic                        clk_i,
  input  logic [acvf_pkg::SQ_STG-1:0] en_i,
  input  logic [31:0]                 z_i,
  output logic [31:0]                 y_o
);

  typedef struct packed {
    logic [27:0] rem;
    logic [24:0] root;
    logic [49:0] rad;
    logic [7:0]  rexp;
    logic        zero;
  } sq_t;

  sq_t sq_in [acvf_pkg::SQ_STG];
  sq_t sq_d  [acvf_pkg::SQ_STG];
  sq_t sq_q  [acvf_pkg::SQ_STG];

  sq_t         init;
  sq_t         cur;
  logic [7:0]  ex;
  logic [23:0] m;
  logic [24:0] mp;
  logic [27:0] r2;
  logic [27:0] trial;

  always_comb begin
    ex = z_i[30:23];
    m  = {1'b1, z_i[22:0]};
    init = '0;
    if (!ex[0]) begin
      mp        = {m, 1'b0};
      init.rexp = 8'(({1'b0, ex} + 9'd126) >> 1);
    end else begin
      mp        = {1'b0, m};
      init.rexp = 8'(({1'b0, ex} + 9'd127) >> 1);
    end
    init.rad  = {mp, 25'b0};
    init.zero = (z_i[30:0] == 31'd0);
    sq_in[0]  = init;
    for (int s = 1; s < acvf_pkg::SQ_STG; s++) begin
      sq_in[s] = sq_q[s - 1];
    end
    r2    = '0;
    trial = '0;
    cur   = init;
    for (int s = 0; s < acvf_pkg::SQ_STG; s++) begin
      cur = sq_in[s];
      // restoring recurrence, one root bit per step
      for (int j = 0; j < acvf_pkg::SQ_ITER; j++) begin
        r2    = {cur.rem[25:0], cur.rad[2 * (24 - acvf_pkg::SQ_ITER * s - j) +: 2]};
        trial = {1'b0, cur.root, 2'b01};
        if (r2 >= trial) begin
          cur.rem  = r2 - trial;
          cur.root = {cur.root[23:0], 1'b1};
        end else begin
          cur.rem  = r2;
          cur.root = {cur.root[23:0], 1'b0};
        end
      end
      sq_d[s] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < acvf_pkg::SQ_STG; s++) begin
      if (en_i[s]) begin
        sq_q[s] <= sq_d[s];
      end
    end
  end

  logic        up;
  logic [24:0] m25;
  logic [7:0]  re;

  always_comb begin
    up  = sq_q[acvf_pkg::SQ_STG-1].root[0] &
          ((|sq_q[acvf_pkg::SQ_STG-1].rem) | sq_q[acvf_pkg::SQ_STG-1].root[1]);
    m25 = {1'b0, sq_q[acvf_pkg::SQ_STG-1].root[24:1]} + {24'b0, up};
    re  = sq_q[acvf_pkg::SQ_STG-1].rexp;
    if (m25[24]) begin
      re  = re + 8'd1;
      m25 = '0;
    end
    y_o = sq_q[acvf_pkg::SQ_STG-1].zero ? 32'd0 : {1'b0, re, m25[22:0]};
  end

endmodule

### hdl/acvf_lane.sv
module acvf_lane (
  input  logic                            clk_i,
  input  logic [acvf_pkg::LANE_STG-1:0]   en_i,
  input  logic [31:0]                     x_i,
  output logic [31:0]                     y_o
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] a;
    logic        near;
    logic        neg;
    logic [31:0] d;
    logic [31:0] zn;
    logic [31:0] z;
    logic [31:0] p;
    logic [31:0] m2;
    logic [31:0] m4;
    logic [31:0] z2;
    logic [31:0] pz;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] z4;
    logic [31:0] m;
    logic [31:0] m5;
    logic [31:0] pl;
    logic [31:0] w;
    logic [31:0] q;
    logic [31:0] t;
  } side_t;

  side_t side_d [acvf_pkg::LANE_STG];
  side_t side_q [acvf_pkg::LANE_STG];

  logic [31:0] d_y, zn_y, zf_y, s_y;
  logic [31:0] m2_y, m4_y, z2_y, pz_y;
  logic [31:0] t1_y, t2_y, z4_y;
  logic [31:0] m_y, m5_y, pl_y, pl2_y, w_y, q_y, t_y, r_y;
  logic [31:0] lo26, hi26, hi24, q_eff;

  always_comb begin
    hi24  = side_q[24].near ? acvf_pkg::K_PIBY4 : acvf_pkg::K_PIBY2;
    lo26  = side_q[24].near ? acvf_pkg::K_PIBY4 : 32'd0;
    q_eff = side_q[24].neg ? side_q[24].q : {~side_q[24].q[31], side_q[24].q[30:0]};
    hi26  = side_q[26].near ? acvf_pkg::K_PIBY4 :
            (side_q[26].neg ? acvf_pkg::K_PIBY2 : 32'd0);
  end

  // a*a and 1-a
  acvf_fadd u_d (.clk_i, .en_i(en_i[1]), .a_i(acvf_pkg::K_ONE),
                 .b_i({1'b1, side_q[0].a[30:0]}), .y_o(d_y));
  acvf_fmul u_zn (.clk_i, .en_i(en_i[1]), .a_i(side_q[0].a), .b_i(side_q[0].a), .y_o(zn_y));
  acvf_fmul u_zf (.clk_i, .en_i(en_i[3]), .a_i(acvf_pkg::K_HALF), .b_i(side_q[2].d),
                  .y_o(zf_y));
  acvf_sqrt u_sqrt (.clk_i, .en_i(en_i[9:5]), .z_i(side_q[4].z), .y_o(s_y));
  // polynomial terms
  acvf_fmul u_m2 (.clk_i, .en_i(en_i[11]), .a_i(acvf_pkg::K_C2), .b_i(side_q[10].z),
                  .y_o(m2_y));
  acvf_fmul u_m4 (.clk_i, .en_i(en_i[11]), .a_i(acvf_pkg::K_C4), .b_i(side_q[10].z),
                  .y_o(m4_y));
  acvf_fmul u_z2 (.clk_i, .en_i(en_i[11]), .a_i(side_q[10].z), .b_i(side_q[10].z),
                  .y_o(z2_y));
  acvf_fmul u_pz (.clk_i, .en_i(en_i[11]), .a_i(side_q[10].p), .b_i(side_q[10].z),
                  .y_o(pz_y));
  acvf_fadd u_t1 (.clk_i, .en_i(en_i[13]), .a_i(acvf_pkg::K_C1), .b_i(side_q[12].m2),
                  .y_o(t1_y));
  acvf_fadd u_t2 (.clk_i, .en_i(en_i[13]), .a_i(acvf_pkg::K_C3), .b_i(side_q[12].m4),
                  .y_o(t2_y));
  acvf_fmul u_z4 (.clk_i, .en_i(en_i[13]), .a_i(side_q[12].z2), .b_i(side_q[12].z2),
                  .y_o(z4_y));
  acvf_fmul u_m (.clk_i, .en_i(en_i[15]), .a_i(side_q[14].z2), .b_i(side_q[14].t2),
                 .y_o(m_y));
  acvf_fmul u_m5 (.clk_i, .en_i(en_i[15]), .a_i(side_q[14].z4), .b_i(acvf_pkg::K_C5),
                  .y_o(m5_y));
  acvf_fadd u_pl (.clk_i, .en_i(en_i[17]), .a_i(side_q[16].t1), .b_i(side_q[16].m),
                  .y_o(pl_y));
  acvf_fadd u_pl2 (.clk_i, .en_i(en_i[19]), .a_i(side_q[18].pl), .b_i(side_q[18].m5),
                   .y_o(pl2_y));
  acvf_fmul u_w (.clk_i, .en_i(en_i[21]), .a_i(side_q[20].pz), .b_i(side_q[20].pl),
                 .y_o(w_y));
  acvf_fadd u_q (.clk_i, .en_i(en_i[23]), .a_i(side_q[22].p), .b_i(side_q[22].w),
                 .y_o(q_y));
  // final reconstruction around pi/4, 0 or pi/2
  acvf_fadd u_t (.clk_i, .en_i(en_i[25]), .a_i(side_q[24].neg ? hi24 : lo26), .b_i(q_eff),
                 .y_o(t_y));
  acvf_fadd u_r (.clk_i, .en_i(en_i[27]), .a_i(side_q[26].t), .b_i(hi26), .y_o(r_y));

  always_comb begin
    side_d[0]      = '0;
    side_d[0].x    = x_i;
    side_d[0].a    = x_i & acvf_pkg::K_ABSMASK;
    side_d[0].near = (x_i & acvf_pkg::K_ABSMASK) <= acvf_pkg::K_HALF;
    side_d[0].neg  = x_i[31];
    for (int k = 1; k < acvf_pkg::LANE_STG; k++) begin
      side_d[k] = side_q[k - 1];
    end
    side_d[2].d   = d_y;
    side_d[2].zn  = zn_y;
    side_d[4].z   = side_q[3].near ? side_q[3].zn : zf_y;
    // far branch argument is -2*sqrt(z), an exact exponent bump
    if (side_q[9].near) begin
      side_d[10].p = side_q[9].a;
    end else if (s_y == 32'd0) begin
      side_d[10].p = 32'h80000000;
    end else begin
      side_d[10].p = {1'b1, s_y[30:23] + 8'd1, s_y[22:0]};
    end
    side_d[12].m2 = m2_y;
    side_d[12].m4 = m4_y;
    side_d[12].z2 = z2_y;
    side_d[12].pz = pz_y;
    side_d[14].t1 = t1_y;
    side_d[14].t2 = t2_y;
    side_d[14].z4 = z4_y;
    side_d[16].m  = m_y;
    side_d[16].m5 = m5_y;
    side_d[18].pl = pl_y;
    side_d[20].pl = pl2_y;
    side_d[22].w  = w_y;
    side_d[24].q  = q_y;
    side_d[26].t  = t_y;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < acvf_pkg::LANE_STG; k++) begin
      if (en_i[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  logic [31:0] ab27;

  always_comb begin
    ab27 = side_q[27].x & acvf_pkg::K_ABSMASK;
    if (ab27 > acvf_pkg::K_INF) begin
      y_o = side_q[27].x | acvf_pkg::K_QBIT;
    end else if (ab27 > acvf_pkg::K_ONE) begin
      y_o = acvf_pkg::K_QNAN;
    end else begin
      y_o = r_y;
    end
  end

endmodule

### hdl/vector_acos_float32_top.sv
// Four-lane single-precision arc cosine. Each input beat carries four IEEE-754
// operands and yields one output beat with acos of each lane, bit exact with
// round-to-nearest-even at every step (polynomial in z, far branch through a
// correctly rounded square root). The block takes one beat per clock cycle unless
// the output side holds a full pipeline. An accepted beat passes through the lane
// pipeline: one input register, eleven dependent float operations of two stages
// each (multiply or align/add, then normalize/round), a five stage square root
// (five root bits per stage, its rounding folded into the stage that forms the
// polynomial argument) and one output register. Every stage holds its beat only
// while the stage behind it is full, so bubbles close up and input is still taken
// while a finished result waits. Reset clears only the stage valid bits and there
// is no configuration.
`include "assert_macros.svh"

module vector_acos_float32_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // x_lane0 [31:0], x_lane1 [63:32], x_lane2 [95:64], x_lane3 [127:96]
  input  logic [acvf_pkg::LANES*32-1:0]    s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // acos_lane0 [31:0], acos_lane1 [63:32], acos_lane2 [95:64], acos_lane3 [127:96]
  output logic [acvf_pkg::LANES*32-1:0]    m_axis_tdata_o
);

  // stage occupancy and per-stage advance
  logic [acvf_pkg::NSTG-1:0] v_q, v_d;
  logic [acvf_pkg::NSTG-1:0] en;

  always_comb begin
    en[acvf_pkg::NSTG-1] = !v_q[acvf_pkg::NSTG-1] || m_axis_tready_i;
    for (int k = acvf_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k + 1];
    end
    v_d[0] = s_axis_tvalid_i;
    for (int k = 1; k < acvf_pkg::NSTG; k++) begin
      v_d[k] = v_q[k - 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < acvf_pkg::NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // lanes work independently on their own operand
  logic [acvf_pkg::LANES*32-1:0] lane_y;

  for (genvar l = 0; l < acvf_pkg::LANES; l++) begin : g_lane
    acvf_lane u_lane (
      .clk_i,
      .en_i (en[acvf_pkg::LANE_STG-1:0]),
      .x_i  (s_axis_tdata_i[32*l +: 32]),
      .y_o  (lane_y[32*l +: 32])
    );
  end

  // merge the lane results into the output beat
  logic [acvf_pkg::LANES*32-1:0] tdata_q;

  always_ff @(posedge clk_i) begin
    if (en[acvf_pkg::NSTG-1]) begin
      tdata_q <= lane_y;
    end
  end

  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tvalid_o = v_q[acvf_pkg::NSTG-1];

  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // beats in flight now and after this edge
  acvf_pkg::cnt_t n_inflight, n_exp;
  assign n_inflight = acvf_pkg::cnt_t'($countones(v_q));
  assign n_exp      = n_inflight + acvf_pkg::cnt_t'(in_fire) - acvf_pkg::cnt_t'(out_fire);

  // an empty output stage never blocks the input
  `ACVF_ASSERT(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled")
  // a stage only holds when it carries a beat
  `ACVF_ASSERT(a_hold_only_full, ((~en) & (~v_q)) == '0, "empty stage held")
  // beats in flight change only by accepted input and delivered output
  `ACVF_ASSERT_NEXT(a_beat_count, 1'b1, n_inflight == $past(n_exp), "beat lost or doubled")

endmodule

### test/testbench.sv
module testbench;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [acvf_pkg::LANES*32-1:0]   s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [acvf_pkg::LANES*32-1:0]   m_axis_tdata_o;

  logic [acvf_pkg::LANES*32-1:0]   pending_acos [$];
  int                              errors = 0;
  bit                              idle_on = 1'b0;

  vector_acos_float32_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---- single-precision arithmetic, round to nearest even ----

  // value = mag * 2^e, mag exact or with a sticky bit at the bottom
  function automatic logic [31:0] round_to_single(logic sgn, logic [127:0] mag, int e);
    int           msb;
    int           bexp;
    int           sh;
    logic [127:0] kept;
    logic         g;
    logic         st;
    if (mag == '0) return {sgn, 31'b0};
    msb = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) msb = i;
    bexp = msb + e + 127;
    if (bexp < 1) bexp = 1;
    sh = bexp - 150 - e;
    g  = 1'b0;
    st = 1'b0;
    if (sh <= 0) begin
      kept = mag << (-sh);
    end else if (sh > 127) begin
      kept = '0;
      st   = 1'b1;
    end else begin
      kept = mag >> sh;
      g    = mag[sh-1];
      st   = (mag & ((128'd1 << (sh - 1)) - 128'd1)) != '0;
    end
    if (g && (st || kept[0])) kept = kept + 128'd1;
    if (kept == (128'd1 << 24)) begin
      kept = kept >> 1;
      bexp++;
    end
    if (bexp >= 255) return {sgn, 8'hFF, 23'b0};
    return {sgn, (kept[23] ? 8'(bexp) : 8'd0), kept[22:0]};
  endfunction

  function automatic logic [23:0] sig_of(logic [31:0] b);
    return {(b[30:23] != 8'd0), b[22:0]};
  endfunction

  function automatic int exp_of(logic [31:0] b);
    return ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic [127:0] prod;
    prod = 128'(sig_of(a)) * 128'(sig_of(b));
    return round_to_single(a[31] ^ b[31], prod, exp_of(a) + exp_of(b));
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0]        big;
    logic [31:0]        sml;
    int                 d;
    logic signed [129:0] va;
    logic signed [129:0] vb;
    logic signed [129:0] sum;
    if (exp_of(a) >= exp_of(b)) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    d  = exp_of(big) - exp_of(sml);
    va = 130'(sig_of(big)) << 100;
    // far below the rounding point the smaller operand only counts as sticky
    vb = (d <= 100) ? (130'(sig_of(sml)) << (100 - d)) : 130'(sig_of(sml) != 24'd0);
    if (big[31]) va = -va;
    if (sml[31]) vb = -vb;
    sum = va + vb;
    if (sum == 0) return {a[31] & b[31], 31'b0};
    if (sum < 0) return round_to_single(1'b1, 128'(-sum), exp_of(big) - 100);
    return round_to_single(1'b0, 128'(sum), exp_of(big) - 100);
  endfunction

  function automatic logic [31:0] fsqrt(logic [31:0] b);
    logic [127:0] m;
    logic [127:0] v;
    logic [127:0] root;
    logic [127:0] bitv;
    int           e;
    if (b[30:0] == '0) return b;
    m = 128'(sig_of(b));
    e = exp_of(b);
    while (!m[23]) begin
      m = m << 1;
      e--;
    end
    if (e & 1) begin
      m = m << 1;
      e--;
    end
    v    = m << 50;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != '0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return round_to_single(1'b0, (root << 1) | 128'(v != '0), (e - 50) / 2 - 1);
  endfunction

  function automatic logic [31:0] acos_single(logic [31:0] x);
    logic [31:0] a;
    logic [31:0] z;
    logic [31:0] p;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] z2;
    logic [31:0] pl;
    logic [31:0] q;
    a = x & acvf_pkg::K_ABSMASK;
    if (a > acvf_pkg::K_INF) return x | acvf_pkg::K_QBIT;
    if (a > acvf_pkg::K_ONE) return acvf_pkg::K_QNAN;
    if (a <= acvf_pkg::K_HALF) begin
      z  = fmul(a, a);
      p  = a;
      lo = acvf_pkg::K_PIBY4;
      hi = acvf_pkg::K_PIBY4;
    end else begin
      z  = fmul(acvf_pkg::K_HALF, fadd(acvf_pkg::K_ONE, a ^ 32'h8000_0000));
      p  = fmul(32'hC000_0000, fsqrt(z));
      lo = 32'h0;
      hi = acvf_pkg::K_PIBY2;
    end
    t1 = fadd(acvf_pkg::K_C1, fmul(acvf_pkg::K_C2, z));
    t2 = fadd(acvf_pkg::K_C3, fmul(acvf_pkg::K_C4, z));
    z2 = fmul(z, z);
    pl = fadd(t1, fmul(z2, t2));
    pl = fadd(pl, fmul(fmul(z2, z2), acvf_pkg::K_C5));
    q  = fadd(p, fmul(fmul(p, z), pl));
    if (x[31]) return fadd(fadd(hi, q), hi);
    return fadd(fadd(lo, q ^ 32'h8000_0000), lo);
  endfunction

  function automatic logic [acvf_pkg::LANES*32-1:0] predict_acos_beat(
      logic [acvf_pkg::LANES*32-1:0] xs);
    logic [acvf_pkg::LANES*32-1:0] r;
    for (int i = 0; i < acvf_pkg::LANES; i++) r[32*i +: 32] = acos_single(xs[32*i +: 32]);
    return r;
  endfunction

  // ---- handshakes ----

  task automatic report_mismatch(string what, int lane, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s lane %0d: got %h expected %h", what, lane, got, want);
    errors++;
  endtask

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic send_beat(logic [acvf_pkg::LANES*32-1:0] xs);
    if (idle_on && $urandom_range(99) < 17) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 17);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= xs;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_acos.push_back(predict_acos_beat(xs));
  endtask

  task automatic go_quiet();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= !(idle_on && $urandom_range(99) < 17);
  end

  always @(posedge clk_i) begin
    logic [acvf_pkg::LANES*32-1:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_acos.size() == 0) begin
        report_mismatch("unexpected beat", 0, m_axis_tdata_o[31:0], 32'h0);
      end else begin
        want = pending_acos.pop_front();
        for (int i = 0; i < acvf_pkg::LANES; i++)
          if (m_axis_tdata_o[32*i +: 32] !== want[32*i +: 32])
            report_mismatch("acos", i, m_axis_tdata_o[32*i +: 32], want[32*i +: 32]);
      end
    end
  end

  // ---- stimulus ----

  function automatic logic [31:0] random_operand();
    logic [7:0] ex;
    case ($urandom_range(9))
      0: return $urandom();
      1: return {1'($urandom()), 8'h7E, 1'b1, 22'($urandom())};
      2: begin
        ex = 8'($urandom_range(0, 127));
        return (ex == 8'd127) ? {1'($urandom()), acvf_pkg::K_ONE[30:0]}
                              : {1'($urandom()), ex, 23'($urandom())};
      end
      default: return {1'($urandom()), 8'($urandom_range(8'h66, 8'h7E)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [acvf_pkg::LANES*32-1:0] random_beat();
    logic [acvf_pkg::LANES*32-1:0] xs;
    for (int i = 0; i < acvf_pkg::LANES; i++) xs[32*i +: 32] = random_operand();
    return xs;
  endfunction

  // plus and minus one, signed zeros, the branch edge at one half, subnormals,
  // NaNs of both kinds and signs, infinities and magnitudes just above one
  task automatic test_special_values();
    logic [31:0] vals [$];
    logic [acvf_pkg::LANES*32-1:0] xs;
    vals = '{32'h3F800000, 32'hBF800000, 32'h00000000, 32'h80000000,
             32'h3F000000, 32'hBF000000, 32'h3F000001, 32'hBF000001,
             32'h00000001, 32'h807FFFFF, 32'h00800000, 32'h3F7FFFFF,
             32'hBF7FFFFF, 32'h7FC00000, 32'hFF800001, 32'h7FBFFFFF,
             32'h7F800000, 32'hFF800000, 32'h3F800001, 32'hBF800001,
             32'h7F7FFFFF, 32'hFFFFFFFF, 32'h3EFFFFFF, 32'h33800000};
    for (int k = 0; k < vals.size(); k += acvf_pkg::LANES) begin
      for (int i = 0; i < acvf_pkg::LANES; i++) xs[32*i +: 32] = vals[(k + i) % vals.size()];
      send_beat(xs);
    end
    // all four lanes at once on the same value
    for (int k = 0; k < 6; k++) send_beat({acvf_pkg::LANES{vals[k]}});
  endtask

  task automatic test_random_back_to_back(int n);
    idle_on = 1'b0;
    for (int k = 0; k < n; k++) send_beat(random_beat());
  endtask

  task automatic test_random_with_gaps(int n);
    idle_on = 1'b1;
    for (int k = 0; k < n; k++) send_beat(random_beat());
  endtask

  // sender holds off until the pipeline has delivered everything
  task automatic test_drain_then_resume(int n);
    go_quiet();
    wait (pending_acos.size() == 0);
    @(posedge clk_i);
    test_random_with_gaps(n);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_random_back_to_back(250);
    test_random_with_gaps(300);
    test_drain_then_resume(270);
    go_quiet();
    wait (pending_acos.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_acos.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/acvf_pkg.sv
hdl/acvf_fmul.sv
hdl/acvf_fadd.sv
hdl/acvf_sqrt.sv
hdl/acvf_lane.sv
hdl/vector_acos_float32_top.sv
test/testbench.sv
